// File: sv/sobel_pkg.sv
// ---------------------------------------------------------------------------
// sobel_pkg
// shared constants for the rgb sobel edge filter
// ---------------------------------------------------------------------------
package sobel_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int WIDTH_BITS  = 12;
  localparam int HEIGHT_BITS = 13;
  localparam int CFG_BITS    = 13;
  localparam int PIX_BITS    = 24;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = 13'd480;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } req_t;

endpackage

// File: sv/sobel_edge_filter_rgb_unit.sv
// ---------------------------------------------------------------------------
// sobel_edge_filter_rgb_unit
// streaming 3x3 sobel edge filter, one magnitude per colour channel
// ---------------------------------------------------------------------------
// Pixels arrive in raster order on the in_ channel (tuser = 1 marks a flush
// word that carries no pixel). Each result word on the out_ channel holds
// the red, green and blue edge magnitudes; tlast marks the final pixel of
// the image. Results lag the pixel stream by one row plus one pixel, so
// after the last pixel of an image width+1 flush words drain the rest.
// Throughput is one word per cycle while out_tready is high; a word goes
// through an input stage, where the line store read is registered, and
// then the result register. The line stores are dual arrays read and
// written once per cycle each.
// Reset clears counters and handshake state and loads the default size;
// line stores need no clearing pass. A config write restarts the image.
// When out_tready is low the result holds, at most one more word is taken
// into the input stage, and then in_tready drops until the result is taken.
// ---------------------------------------------------------------------------
module sobel_edge_filter_rgb_unit
  import sobel_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [PIX_BITS-1:0] in_tdata,   // in_pixel
  input  logic                in_tuser,   // req_type
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [PIX_BITS-1:0] out_tdata,  // out_red, out_green, out_blue
  output logic                out_tlast,  // last_pixel
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  logic [WIDTH_BITS-1:0]  width_r;
  logic [HEIGHT_BITS-1:0] height_r;
  logic [CW:0]            w_eff;
  logic [RW-1:0]          h_eff;

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;

  logic [PIX_BITS-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_BITS-1:0] mid_mem   [MAX_WIDTH];

  logic                s1_v_r;
  logic [CW-1:0]       s1_addr_r;
  logic [PIX_BITS-1:0] s1_px_r;
  logic [PIX_BITS-1:0] s1_up_r;
  logic [PIX_BITS-1:0] s1_mid_r;
  logic [PIX_BITS-1:0] s1_fwd_r;
  logic                s1_fwd_sel_r;
  logic                s1_emit_r;
  logic                s1_last_r;
  logic                s1_ge1_r;
  logic                s1_ge2_r;
  logic                s1_c0_r;

  logic [PIX_BITS-1:0] win_r [6];

  logic                out_v_r;
  logic [PIX_BITS-1:0] out_data_r;
  logic                out_last_r;

  logic          accept, drain, process, adv;
  logic          emit, last, wrap;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_nxt;

  logic [PIX_BITS-1:0] up_val, col0, col1, col2, r0, r1, r2;
  logic [PIX_BITS-1:0] mag;

  function automatic logic [7:0] magnitude(
    input logic [7:0] l0, l1, l2, c0, c2, rr0, rr1, rr2
  );
    logic signed [11:0] gx, gy;
    logic        [10:0] ax, ay;
    logic        [10:0] s;
    gx = $signed({4'b0000, rr0} + {3'b000, rr1, 1'b0} + {4'b0000, rr2})
       - $signed({4'b0000, l0} + {3'b000, l1, 1'b0} + {4'b0000, l2});
    gy = $signed({4'b0000, l2} + {3'b000, c2, 1'b0} + {4'b0000, rr2})
       - $signed({4'b0000, l0} + {3'b000, c0, 1'b0} + {4'b0000, rr0});
    ax = gx[11] ? 11'(-gx) : 11'(gx);
    ay = gy[11] ? 11'(-gy) : 11'(gy);
    s  = (ax + ay) >> 1;
    return (s > 11'd255) ? 8'd255 : s[7:0];
  endfunction

  // effective image size
  always_comb begin
    if (width_r == '0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(width_r);
    end
    if (height_r == '0) begin
      h_eff = RW'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(height_r);
    end
  end

  // handshake and raster position
  always_comb begin
    adv       = s1_v_r && (!out_v_r || out_tready);
    in_tready = !s1_v_r || adv;
    accept    = in_tvalid && in_tready;
    drain     = row_r >= h_eff;
    process   = accept && (drain || (req_t'(in_tuser) == REQ_PIXEL));
    emit      = (row_r >= RW'(2)) || ((row_r == RW'(1)) && (col_r != '0));
    last      = (col_r == '0) && (row_r == h_eff + RW'(1));
    wrap      = ((CW+1)'(col_r) + (CW+1)'(1)) == w_eff;
    if (last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (wrap) begin
      col_nxt = '0;
      row_nxt = row_r + RW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WIDTH_BITS-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[HEIGHT_BITS-1:0];
      endcase
      col_r <= '0;
      row_r <= '0;
    end else if (process) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line stores
  always_ff @(posedge clk) begin
    if (process) begin
      s1_up_r  <= upper_mem[col_r];
      s1_mid_r <= mid_mem[col_r];
      mid_mem[col_r] <= drain ? '0 : in_tdata;
    end
    if (s1_v_r) begin
      upper_mem[s1_addr_r] <= s1_mid_r;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= process;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      s1_addr_r    <= col_r;
      s1_px_r      <= drain ? '0 : in_tdata;
      s1_fwd_r     <= s1_mid_r;
      s1_fwd_sel_r <= s1_v_r && (s1_addr_r == col_r);
      s1_emit_r    <= emit;
      s1_last_r    <= last;
      s1_ge1_r     <= row_r >= RW'(1);
      s1_ge2_r     <= row_r >= RW'(2);
      s1_c0_r      <= col_r == '0;
    end
  end

  // window and magnitudes
  always_comb begin
    up_val = s1_fwd_sel_r ? s1_fwd_r : s1_up_r;
    col0   = s1_ge2_r ? up_val : '0;
    col1   = s1_ge1_r ? s1_mid_r : '0;
    col2   = s1_px_r;
    r0     = s1_c0_r ? '0 : col0;
    r1     = s1_c0_r ? '0 : col1;
    r2     = s1_c0_r ? '0 : col2;
    for (int k = 0; k < 3; k++) begin
      mag[8*k +: 8] = magnitude(win_r[0][8*k +: 8], win_r[1][8*k +: 8],
                                win_r[2][8*k +: 8], win_r[3][8*k +: 8],
                                win_r[5][8*k +: 8], r0[8*k +: 8],
                                r1[8*k +: 8], r2[8*k +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win_r[0] <= s1_c0_r ? '0 : win_r[3];
      win_r[1] <= s1_c0_r ? '0 : win_r[4];
      win_r[2] <= s1_c0_r ? '0 : win_r[5];
      win_r[3] <= col0;
      win_r[4] <= col1;
      win_r[5] <= col2;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && s1_emit_r) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_emit_r) begin
      out_data_r <= mag;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
